### rtl/imnu_pkg.sv
// ----------------------------------------------------------------------------
// imnu_pkg
// shared types and constants of the integer matrix norm unit
// ----------------------------------------------------------------------------
`default_nettype none

package imnu_pkg;

    // matrix size limits
    localparam int ROWS_MAX = 256;
    localparam int COLS_MAX = 256;
    localparam int ROW_W    = $clog2(ROWS_MAX);
    localparam int COL_W    = $clog2(COLS_MAX);

    // field and accumulator widths
    localparam int VALUE_W  = 32;
    localparam int ABS_W    = VALUE_W + 1;
    localparam int ACC_W    = 40;
    localparam int NORM_W   = 48;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam int MODE_W     = 2;
    localparam int SIZE_W     = 9;

    localparam logic [CFG_ADDR_W-1:0] CFG_MODE = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_ROWS = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_COLS = CFG_ADDR_W'(2);

    typedef enum logic [MODE_W-1:0] {
        MODE_ONE_NORM = 2'd0,
        MODE_INF_NORM = 2'd1,
        MODE_ABS_SUM  = 2'd2,
        MODE_MAX_ABS  = 2'd3
    } mode_t;

endpackage

`default_nettype wire

### rtl/integer_matrix_norm_unit.sv
// ----------------------------------------------------------------------------
// integer_matrix_norm_unit
// one-norm, infinity-norm, absolute sum or max absolute of an integer matrix
// ----------------------------------------------------------------------------
// norm beat path: last entry beat, compute stage register, output register
// throughput: one entry beat per cycle while no norm waits on a full output,
//   set by the row-total memory's registered read-modify-write and forwarding
// reset: synchronous, clears registers, positions and handshake state; the
//   row-total memory is not cleared since column 0 always overwrites a row
`default_nettype none

module integer_matrix_norm_unit
    import imnu_pkg::*;
(
    input  wire  logic                   aclk,
    input  wire  logic                   aresetn,

    // configuration write port
    input  wire  logic                   cfg_wr_en,
    input  wire  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire  logic [CFG_DATA_W-1:0]  cfg_wdata,

    // entry beats, column-major order
    input  wire  logic                   s_valid,
    output logic                         s_ready,
    input  wire  logic signed [VALUE_W-1:0] s_value,

    // norm beats
    output logic                         m_valid,
    input  wire  logic                   m_ready,
    output logic [NORM_W-1:0]            m_norm
);

    // configuration registers
    mode_t               mode_reg;
    logic [SIZE_W-1:0]   rows_reg;
    logic [SIZE_W-1:0]   cols_reg;

    // position of the next entry
    logic [ROW_W-1:0]    row_pos_reg;
    logic [COL_W-1:0]    col_pos_reg;

    // accumulators
    logic [ACC_W-1:0]    col_total_reg;
    logic [NORM_W-1:0]   best_reg;

    // compute stage
    logic                s1_valid_reg;
    mode_t               s1_mode_reg;
    logic [ABS_W-1:0]    s1_abs_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic                s1_first_row_reg;
    logic                s1_first_col_reg;
    logic                s1_last_row_reg;
    logic                s1_last_col_reg;

    // row-total memory and its read data / forwarding path
    logic [ACC_W-1:0]    row_mem [ROWS_MAX];
    logic [ACC_W-1:0]    rd_data_reg;
    logic                fwd_valid_reg;
    logic [ACC_W-1:0]    fwd_data_reg;

    // output register
    logic                m_valid_reg;
    logic [NORM_W-1:0]   m_norm_reg;

    // ------------------------------------------------------------------------
    // entry side: clamp sizes and positions, absolute value
    // ------------------------------------------------------------------------
    logic [ROW_W-1:0]    last_row_idx;
    logic [COL_W-1:0]    last_col_idx;
    logic [ROW_W-1:0]    row_sel;
    logic [COL_W-1:0]    col_sel;
    logic                is_last_row;
    logic                is_last_col;
    logic [ABS_W-1:0]    value_ext;
    logic [ABS_W-1:0]    value_abs;
    logic                s_fire;
    logic                s1_adv;

    always_comb begin
        // zero size acts as one, oversize saturates at the maximum
        if (rows_reg == '0) begin
            last_row_idx = '0;
        end else if (32'(rows_reg) > ROWS_MAX) begin
            last_row_idx = ROW_W'(ROWS_MAX - 1);
        end else begin
            last_row_idx = ROW_W'(rows_reg - 1'b1);
        end

        if (cols_reg == '0) begin
            last_col_idx = '0;
        end else if (32'(cols_reg) > COLS_MAX) begin
            last_col_idx = COL_W'(COLS_MAX - 1);
        end else begin
            last_col_idx = COL_W'(cols_reg - 1'b1);
        end

        // a position left past a shrunken size is pulled back to the last index
        row_sel = (row_pos_reg > last_row_idx) ? last_row_idx : row_pos_reg;
        col_sel = (col_pos_reg > last_col_idx) ? last_col_idx : col_pos_reg;
        is_last_row = (row_sel == last_row_idx);
        is_last_col = (col_sel == last_col_idx);

        // exact absolute value, the most negative entry included
        value_ext = {s_value[VALUE_W-1], s_value};
        value_abs = value_ext[ABS_W-1] ? (~value_ext + 1'b1) : value_ext;
    end

    // the compute stage holds only when it carries a norm and the output is full
    assign s1_adv  = !(s1_last_row_reg && s1_last_col_reg && m_valid_reg && !m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_fire  = s_valid && s_ready;

    // ------------------------------------------------------------------------
    // compute stage: one add and compare per entry
    // ------------------------------------------------------------------------
    logic [NORM_W-1:0]   best_base;
    logic [ACC_W-1:0]    abs_acc;
    logic [ACC_W-1:0]    row_src;
    logic [ACC_W-1:0]    col_sum;
    logic [ACC_W-1:0]    row_sum;
    logic [ACC_W-1:0]    col_total_next;
    logic [NORM_W-1:0]   best_next;
    logic                s1_fire;
    logic                mem_we;

    always_comb begin
        // start of a matrix clears the running result
        best_base = (s1_first_row_reg && s1_first_col_reg) ? '0 : best_reg;
        abs_acc   = ACC_W'(s1_abs_reg);
        // back-to-back hit on one row word takes the value still being written
        row_src   = fwd_valid_reg ? fwd_data_reg : rd_data_reg;
        col_sum   = s1_first_row_reg ? abs_acc : col_total_reg + abs_acc;
        row_sum   = s1_first_col_reg ? abs_acc : row_src + abs_acc;

        col_total_next = col_total_reg;
        best_next      = best_base;

        unique case (s1_mode_reg)
            MODE_ONE_NORM: begin
                col_total_next = col_sum;
                if (s1_last_row_reg && (NORM_W'(col_sum) > best_base)) begin
                    best_next = NORM_W'(col_sum);
                end
            end
            MODE_INF_NORM: begin
                if (s1_last_col_reg && (NORM_W'(row_sum) > best_base)) begin
                    best_next = NORM_W'(row_sum);
                end
            end
            MODE_ABS_SUM: begin
                best_next = best_base + NORM_W'(s1_abs_reg);
            end
            MODE_MAX_ABS: begin
                if (NORM_W'(s1_abs_reg) > best_base) begin
                    best_next = NORM_W'(s1_abs_reg);
                end
            end
            default: begin
                best_next = best_base;
            end
        endcase
    end

    assign s1_fire = s1_valid_reg && s1_adv;
    assign mem_we  = s1_fire && (s1_mode_reg == MODE_INF_NORM);

    // ------------------------------------------------------------------------
    // row-total memory, read on entry, written from the compute stage
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            row_mem[s1_row_reg] <= row_sum;
        end
        if (s_fire) begin
            rd_data_reg <= row_mem[row_sel];
        end
    end

    // ------------------------------------------------------------------------
    // control and state registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_ONE_NORM;
            rows_reg      <= SIZE_W'(1);
            cols_reg      <= SIZE_W'(1);
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            col_total_reg <= '0;
            best_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            // register writes restart the matrix; unknown indices do nothing
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_MODE: begin
                        mode_reg    <= mode_t'(cfg_wdata[MODE_W-1:0]);
                        row_pos_reg <= '0;
                        col_pos_reg <= '0;
                    end
                    CFG_ROWS: begin
                        rows_reg    <= cfg_wdata[SIZE_W-1:0];
                        row_pos_reg <= '0;
                        col_pos_reg <= '0;
                    end
                    CFG_COLS: begin
                        cols_reg    <= cfg_wdata[SIZE_W-1:0];
                        row_pos_reg <= '0;
                        col_pos_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end

            // entry beat: step the position and load the compute stage
            if (s_fire) begin
                if (is_last_row) begin
                    row_pos_reg <= '0;
                    col_pos_reg <= is_last_col ? '0 : col_sel + 1'b1;
                end else begin
                    row_pos_reg <= row_sel + 1'b1;
                    col_pos_reg <= col_sel;
                end
                fwd_valid_reg <= mem_we && (s1_row_reg == row_sel);
            end

            if (s_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire) begin
                col_total_reg <= col_total_next;
                best_reg      <= best_next;
            end

            // output register takes the norm on the matrix's last entry
            if (s1_fire && s1_last_row_reg && s1_last_col_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_mode_reg      <= mode_reg;
            s1_abs_reg       <= value_abs;
            s1_row_reg       <= row_sel;
            s1_first_row_reg <= (row_sel == '0);
            s1_first_col_reg <= (col_sel == '0);
            s1_last_row_reg  <= is_last_row;
            s1_last_col_reg  <= is_last_col;
            fwd_data_reg     <= row_sum;
        end
        if (s1_fire && s1_last_row_reg && s1_last_col_reg) begin
            m_norm_reg <= best_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_norm  = m_norm_reg;

endmodule

`default_nettype wire

### tb/integer_matrix_norm_unit_test.sv
// ----------------------------------------------------------------------------
// integer_matrix_norm_unit_test
// self-checking bench for the integer matrix norm unit: streams matrices in
// column order under every mode and many shapes, predicts each norm in a
// scoreboard class and checks every norm beat against the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

module integer_matrix_norm_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import imnu_pkg::*;

    // index that maps to no register
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = CFG_ADDR_W'(3);

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    localparam int unsigned ENTRY_TARGET  = 1900;  // stimulus stops past this
    localparam int unsigned PRESSURE_AT   = 1000;  // long receiver hold-off here
    localparam int unsigned QUIET_FROM    = 1650;  // no idling after this
    localparam int unsigned HOLD_CYCLES   = 80;
    localparam int unsigned SETTLE_CYCLES = 8;

    // ------------------------------------------------------------------------
    // norm predictor and store of pending norms
    // ------------------------------------------------------------------------
    class norm_scoreboard;
        logic [MODE_W-1:0] mode_q;
        logic [SIZE_W-1:0] rows_q;
        logic [SIZE_W-1:0] cols_q;
        int unsigned       row_pos;
        int unsigned       col_pos;
        logic [ACC_W-1:0]  column_total;
        logic [NORM_W-1:0] best_or_sum;
        logic [ACC_W-1:0]  row_totals [ROWS_MAX];
        logic [NORM_W-1:0] expected_norms [$];
        int unsigned       failures;

        function new();
            mode_q       = MODE_ONE_NORM;
            rows_q       = 1;
            cols_q       = 1;
            row_pos      = 0;
            col_pos      = 0;
            column_total = '0;
            best_or_sum  = '0;
            failures     = 0;
            foreach (row_totals[i]) row_totals[i] = '0;
        endfunction

        // zero counts as one, oversize saturates
        static function int unsigned size_in_use(logic [SIZE_W-1:0] v, int unsigned limit);
            if (v == 0) return 1;
            if (v > limit) return limit;
            return v;
        endfunction

        function void flag(string what, logic [NORM_W-1:0] want, logic [NORM_W-1:0] got);
            failures++;
            if (failures <= 10)
                $display("%0t norm check failed (%s): expected %0d, got %0d",
                         $realtime, what, want, got);
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MODE: mode_q = data[MODE_W-1:0];
                CFG_ROWS: rows_q = data[SIZE_W-1:0];
                CFG_COLS: cols_q = data[SIZE_W-1:0];
                default:  return;
            endcase
            // any real register write restarts the matrix
            row_pos = 0;
            col_pos = 0;
        endfunction

        function void note_entry(logic signed [VALUE_W-1:0] v);
            int unsigned             nr;
            int unsigned             nc;
            int unsigned             r;
            int unsigned             c;
            logic signed [ABS_W-1:0] wide;
            logic [ABS_W-1:0]        mag;
            logic [ACC_W-1:0]        row_sum;
            bit                      last_row;
            bit                      last_col;

            nr = size_in_use(rows_q, ROWS_MAX);
            nc = size_in_use(cols_q, COLS_MAX);
            r  = (row_pos >= nr) ? nr - 1 : row_pos;
            c  = (col_pos >= nc) ? nc - 1 : col_pos;
            last_row = (r == nr - 1);
            last_col = (c == nc - 1);

            // one extra bit keeps the magnitude of the most negative entry exact
            wide = v;
            mag  = (wide < 0) ? -wide : wide;

            if (r == 0 && c == 0) best_or_sum = '0;

            case (mode_t'(mode_q))
                MODE_ONE_NORM: begin
                    column_total = (r == 0) ? ACC_W'(mag) : column_total + ACC_W'(mag);
                    if (last_row && NORM_W'(column_total) > best_or_sum)
                        best_or_sum = NORM_W'(column_total);
                end
                MODE_INF_NORM: begin
                    row_sum = (c == 0) ? ACC_W'(mag) : row_totals[r % ROWS_MAX] + ACC_W'(mag);
                    row_totals[r % ROWS_MAX] = row_sum;
                    if (last_col && NORM_W'(row_sum) > best_or_sum)
                        best_or_sum = NORM_W'(row_sum);
                end
                MODE_ABS_SUM:
                    best_or_sum = best_or_sum + NORM_W'(mag);
                default:
                    if (NORM_W'(mag) > best_or_sum) best_or_sum = NORM_W'(mag);
            endcase

            if (last_row) begin
                row_pos = 0;
                if (last_col) begin
                    col_pos = 0;
                    expected_norms.push_back(best_or_sum);
                end else begin
                    col_pos = c + 1;
                end
            end else begin
                row_pos = r + 1;
                col_pos = c;
            end
        endfunction

        function void check_norm(logic [NORM_W-1:0] got);
            logic [NORM_W-1:0] want;
            if (expected_norms.size() == 0) begin
                flag("no norm pending", '0, got);
                return;
            end
            want = expected_norms.pop_front();
            if (got !== want) flag("norm value", want, got);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, dut ports and bench state
    // ------------------------------------------------------------------------
    logic                        aclk;
    logic                        aresetn   = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]       cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]       cfg_wdata = '0;
    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    logic signed [VALUE_W-1:0]   s_value   = '0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    logic [NORM_W-1:0]           m_norm;

    norm_scoreboard sb;
    int unsigned    entries_sent = 0;
    int unsigned    tx_gap_pct   = 0;   // chance of a sender gap before a beat
    int unsigned    rx_gap_pct   = 0;   // chance of a receiver stall per cycle
    bit             quiet        = 1'b0; // last stretch: no idling on either side
    bit             hold_off_req = 1'b0; // asks the receiver for one long hold-off

    integer_matrix_norm_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_norm    (m_norm)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // driving tasks
    // ------------------------------------------------------------------------

    // one entry beat; valid stays up after acceptance so back-to-back beats
    // never drop it within a step
    task automatic send_entry(logic signed [VALUE_W-1:0] v);
        if (!quiet && $urandom_range(99) < tx_gap_pct) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat ($urandom_range(2)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_value = v;
        do @(posedge aclk); while (!s_ready);
        sb.note_entry(v);
        entries_sent++;
    endtask

    // half corner and small values, half full-range noise
    function automatic logic signed [VALUE_W-1:0] random_entry();
        case ($urandom_range(9))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return '0;
            3:       return '1;
            4:       return VALUE_W'(int'($urandom_range(200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_entries(int unsigned n);
        repeat (n) send_entry(random_entry());
    endtask

    // drop valid, wait out every pending norm, then let the pipe settle
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.expected_norms.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        @(posedge aclk);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // mode always written (upper data bits random), sizes as asked
    task automatic set_shape(logic [MODE_W-1:0] m, logic [SIZE_W-1:0] nr,
                             logic [SIZE_W-1:0] nc, bit wr_rows, bit wr_cols);
        logic [CFG_DATA_W-1:0] d;
        drain();
        d = CFG_DATA_W'($urandom);
        d[MODE_W-1:0] = m;
        set_reg(CFG_MODE, d);
        if (wr_rows) set_reg(CFG_ROWS, nr);
        if (wr_cols) set_reg(CFG_COLS, nc);
    endtask

    // ------------------------------------------------------------------------
    // receiver: random short stalls, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (!quiet && $urandom_range(99) < rx_gap_pct) begin
                m_ready = 1'b0;
                repeat ($urandom_range(2)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // norm beats checked at the edge they are taken
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_norm(m_norm);
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned       phase_no;
        int unsigned       n_mat;
        int unsigned       cells;
        logic [MODE_W-1:0] m_sel;
        logic [SIZE_W-1:0] cur_rows;
        logic [SIZE_W-1:0] cur_cols;
        logic [SIZE_W-1:0] new_rows;
        logic [SIZE_W-1:0] new_cols;
        logic [SIZE_W-1:0] big;
        bit                big_shape;
        bit                wr_rows;
        bit                wr_cols;
        bit                pressure_done;

        sb = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        tx_gap_pct = 30;
        rx_gap_pct = 30;

        // reset shape: one-norm of a 1x1 matrix holding the most negative entry
        send_entry(VALUE_MIN);

        // one-norm with both extremes in one column
        set_shape(MODE_ONE_NORM, 2, 2, 1'b1, 1'b1);
        send_entry(VALUE_MIN);
        send_entry(VALUE_MAX);
        send_entry(-1);
        send_entry(0);

        // infinity-norm, row 0 holds two most negative entries
        set_shape(MODE_INF_NORM, 2, 2, 1'b1, 1'b1);
        send_entry(VALUE_MIN);
        send_entry(1);
        send_entry(VALUE_MIN);
        send_entry(VALUE_MAX);

        // zero rows counts as one row
        set_shape(MODE_ABS_SUM, 0, 3, 1'b1, 1'b1);
        repeat (3) send_entry(VALUE_MIN);

        set_shape(MODE_MAX_ABS, 2, 1, 1'b1, 1'b1);
        send_entry(5);
        send_entry(VALUE_MIN);

        // a write to the unused index must leave the matrix running
        set_shape(MODE_ABS_SUM, 2, 1, 1'b1, 1'b1);
        send_entry(7);
        drain();
        set_reg(CFG_UNUSED, '1);
        send_entry(-9);

        // a real write drops the unfinished matrix
        set_shape(MODE_ABS_SUM, 3, 1, 1'b1, 1'b1);
        send_entry(100);
        send_entry(200);
        drain();
        set_reg(CFG_ROWS, 2);
        send_entry(3);
        send_entry(VALUE_MIN);

        cur_rows      = 2;
        cur_cols      = 1;
        phase_no      = 0;
        pressure_done = 1'b0;

        // random phases: new shape and mode, then whole matrices, now and
        // then an unfinished one that the next write throws away
        while (entries_sent < ENTRY_TARGET || !pressure_done) begin
            phase_no++;
            quiet      = (entries_sent >= QUIET_FROM);
            tx_gap_pct = 25 * $urandom_range(2);
            rx_gap_pct = 25 * $urandom_range(2);
            m_sel      = MODE_W'($urandom_range(3));

            if (phase_no == 1) begin
                // oversize rows saturate; every row word gets a read-modify-write
                set_shape(MODE_INF_NORM, 511, 2, 1'b1, 1'b1);
                cur_rows = 511;
                cur_cols = 2;
                n_mat    = 1;
            end else if (phase_no == 2) begin
                set_shape(MODE_ONE_NORM, 1, 300, 1'b1, 1'b1);
                cur_rows = 1;
                cur_cols = 300;
                n_mat    = 1;
            end else if (!pressure_done && entries_sent >= PRESSURE_AT) begin
                // one norm per beat while the receiver holds off: input backs up
                set_shape(m_sel, 1, 1, 1'b1, 1'b1);
                cur_rows      = 1;
                cur_cols      = 1;
                tx_gap_pct    = 0;
                hold_off_req  = 1'b1;
                pressure_done = 1'b1;
                n_mat         = 48;
            end else begin
                new_rows = SIZE_W'($urandom_range(6));
                new_cols = SIZE_W'($urandom_range(6));
                // large shapes only early enough to stay near the entry target
                big_shape = (entries_sent + 2 * ROWS_MAX < QUIET_FROM)
                         && ($urandom_range(24) == 0);
                if (big_shape) begin
                    big = ($urandom_range(2) == 0) ? SIZE_W'(256)
                                                   : SIZE_W'($urandom_range(255, 511));
                    if ($urandom_range(1)) begin
                        new_rows = big;
                        new_cols = SIZE_W'($urandom_range(1, 2));
                    end else begin
                        new_cols = big;
                        new_rows = SIZE_W'($urandom_range(1, 2));
                    end
                end
                // a large size left from before is always replaced
                wr_rows = big_shape || (cur_rows > 6) || ($urandom_range(1) != 0);
                wr_cols = big_shape || (cur_cols > 6) || ($urandom_range(1) != 0);
                set_shape(m_sel, new_rows, new_cols, wr_rows, wr_cols);
                if (wr_rows) cur_rows = new_rows;
                if (wr_cols) cur_cols = new_cols;
                n_mat = big_shape ? 1 : $urandom_range(1, 4);
            end

            cells = norm_scoreboard::size_in_use(cur_rows, ROWS_MAX)
                  * norm_scoreboard::size_in_use(cur_cols, COLS_MAX);
            repeat (n_mat) send_entries(cells);
            if (cells > 1 && $urandom_range(9) == 0)
                send_entries($urandom_range(1, cells - 1));
        end

        drain();

        if (sb.failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
